[sv/assert_macros.svh]
// Assertion macros used by the scheduler RTL.
// Each macro takes a label, the clock, the reset and a property or condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[sv/eds_pkg.sv]
package eds_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W       = 8;
  localparam int CYL_W       = 8;
  localparam int TRK_W       = 5;
  localparam int BLK_W       = 3;

  // Command codes carried in the input tuser.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // Status codes carried in the output tuser.
  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [1:0] STATUS_SERVED   = 2'd2;
  localparam logic [1:0] STATUS_REVERSED = 2'd3;

  // One queued request.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CYL_W-1:0] cylinder;
    logic [TRK_W-1:0] track;
    logic [BLK_W-1:0] blk;
  } entry_t;

  // Head position, sweep direction and queue count seen by every cell.
  typedef struct packed {
    logic [CYL_W-1:0]   head_cylinder;
    logic [BLK_W-1:0]   head_block;
    logic               outward;
    logic [COUNT_W-1:0] count;
  } scan_ctx_t;

  // Best candidate so far, passed from cell to cell during a service scan.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [CYL_W-1:0] cyl_dist;
    logic [BLK_W-1:0] bdist;
    logic [IDX_W-1:0] idx;
  } scan_t;

endpackage

[sv/elevator_disk_request_scheduler.sv]
// An insert's result appears in the cycle after it is accepted; one insert is taken
// each cycle while the output is free. In a service step the best candidate walks
// the row of QUEUE_DEPTH cells one cell a cycle, then is served and the queue shifted,
// or the sweep reverses if none was found. No command is taken until the step commits.
// Reset empties the queue, sets the head to cylinder 0, block 0, and the sweep to inward.
// Stored request entries are not cleared by reset.
`include "assert_macros.svh"

module elevator_disk_request_scheduler import eds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: request_tag [7:0], request_cylinder [15:8], request_track [20:16],
  // request_block [23:21]
  input  logic [23:0] s_axis_tdata,
  // tuser: command [0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: served_tag [7:0], served_cylinder [15:8], served_track [20:16],
  // served_block [23:21], sweep_outward [24], pending_count [29:25], zero [31:30]
  output logic [31:0] m_axis_tdata,
  // tuser: status [1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state;
  logic [COUNT_W-1:0] count;
  logic [CYL_W-1:0]   head_cylinder;
  logic [BLK_W-1:0]   head_block;
  logic               outward;
  scan_t              best;

  logic               out_free;
  logic               accept;
  logic               do_insert;
  logic               full;
  logic               commit;
  entry_t             in_entry;
  entry_t             picked;
  scan_ctx_t          ctx;
  scan_t              scan_head;
  entry_t             entries [QUEUE_DEPTH];
  scan_t              chain   [QUEUE_DEPTH+1];

  // Handshake and control decode.
  always_comb begin
    out_free      = !m_axis_tvalid || m_axis_tready;
    s_axis_tready = (state == ST_IDLE) && out_free;
    accept        = s_axis_tvalid && s_axis_tready;
    full          = (count == COUNT_W'(QUEUE_DEPTH));
    do_insert     = accept && (s_axis_tuser[0] == CMD_INSERT) && !full;
    commit        = (state == ST_DONE) && out_free;
    in_entry.tag      = s_axis_tdata[7:0];
    in_entry.cylinder = s_axis_tdata[15:8];
    in_entry.track    = s_axis_tdata[20:16];
    in_entry.blk      = s_axis_tdata[23:21];
    ctx.head_cylinder = head_cylinder;
    ctx.head_block    = head_block;
    ctx.outward       = outward;
    ctx.count         = count;
    scan_head.valid    = accept && (s_axis_tuser[0] == CMD_SERVICE);
    scan_head.found    = 1'b0;
    scan_head.cyl_dist = '0;
    scan_head.bdist    = '0;
    scan_head.idx      = '0;
    picked            = entries[best.idx];
  end

  assign chain[0] = scan_head;

  // Row of cells, one request each.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t neighbour;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign neighbour = '0;
    end else begin : g_mid
      assign neighbour = entries[i+1];
    end
    eds_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .ctx        (ctx),
      .load       (do_insert),
      .load_entry (in_entry),
      .shift      (commit && best.found),
      .pick       (best.idx),
      .next_entry (neighbour),
      .entry      (entries[i]),
      .scan_in    (chain[i]),
      .scan_out   (chain[i+1])
    );
  end

  // Sequencer, queue state and head position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      head_cylinder <= '0;
      head_block    <= '0;
      outward       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (scan_head.valid) begin
            state <= ST_SCAN;
          end else if (do_insert) begin
            count <= count + COUNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (chain[QUEUE_DEPTH].valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state <= ST_IDLE;
            if (best.found) begin
              head_cylinder <= picked.cylinder;
              head_block    <= picked.blk;
              count         <= count - COUNT_W'(1);
            end else begin
              outward <= !outward;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the outcome of the scan at the end of the row.
  always_ff @(posedge clk) begin
    if (chain[QUEUE_DEPTH].valid) begin
      best <= chain[QUEUE_DEPTH];
    end
  end

  // Output register for result items.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && (s_axis_tuser[0] == CMD_INSERT)) begin
      m_axis_tvalid       <= 1'b1;
      m_axis_tuser        <= full ? STATUS_DROPPED : STATUS_INSERTED;
      m_axis_tdata[23:0]  <= '0;
      m_axis_tdata[24]    <= outward;
      m_axis_tdata[29:25] <= full ? count : count + COUNT_W'(1);
      m_axis_tdata[31:30] <= '0;
    end else if (commit) begin
      m_axis_tvalid       <= 1'b1;
      m_axis_tdata[31:30] <= '0;
      if (best.found) begin
        m_axis_tuser        <= STATUS_SERVED;
        m_axis_tdata[7:0]   <= picked.tag;
        m_axis_tdata[15:8]  <= picked.cylinder;
        m_axis_tdata[20:16] <= picked.track;
        m_axis_tdata[23:21] <= picked.blk;
        m_axis_tdata[24]    <= outward;
        m_axis_tdata[29:25] <= count - COUNT_W'(1);
      end else begin
        m_axis_tuser        <= STATUS_REVERSED;
        m_axis_tdata[23:0]  <= '0;
        m_axis_tdata[24]    <= !outward;
        m_axis_tdata[29:25] <= count;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // The queue never holds more than its depth.
  `ASSERT_NEVER(a_count_bound, clk, rst, count > COUNT_W'(QUEUE_DEPTH))
  // The scan candidate leaves the last cell only while a scan is running.
  `ASSERT_PROP(a_scan_end_in_scan, clk, rst, chain[QUEUE_DEPTH].valid |-> state == ST_SCAN)
  // Serving a request removes exactly one entry.
  `ASSERT_PROP(a_serve_pops, clk, rst,
    (commit && best.found) |=> count == $past(count) - COUNT_W'(1))
  // A reversal moves no head and keeps the queue as it was.
  `ASSERT_PROP(a_reverse_keeps, clk, rst,
    (commit && !best.found) |=>
      (count == $past(count)) && (head_cylinder == $past(head_cylinder)))

endmodule

[sv/eds_cell.sv]
module eds_cell import eds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  scan_ctx_t        ctx,
  input  logic             load,
  input  entry_t           load_entry,
  input  logic             shift,
  input  logic [IDX_W-1:0] pick,
  input  entry_t           next_entry,
  output entry_t           entry,
  input  scan_t            scan_in,
  output scan_t            scan_out
);

  logic             occupied;
  logic             ahead;
  logic [CYL_W-1:0] cyl_dist;
  logic [BLK_W-1:0] bdist;
  logic             take;

  // Entry storage: append at the fill position, or close the gap left by a
  // served entry by taking the neighbour's contents.
  always_ff @(posedge clk) begin
    if (load && ({1'b0, cell_index} == ctx.count)) begin
      entry <= load_entry;
    end else if (shift && (cell_index >= pick)) begin
      entry <= next_entry;
    end
  end

  // Directed cylinder distance and absolute block distance to the head.
  always_comb begin
    occupied = ({1'b0, cell_index} < ctx.count);
    if (ctx.outward) begin
      ahead    = (entry.cylinder <= ctx.head_cylinder);
      cyl_dist = ctx.head_cylinder - entry.cylinder;
    end else begin
      ahead    = (entry.cylinder >= ctx.head_cylinder);
      cyl_dist = entry.cylinder - ctx.head_cylinder;
    end
    if (entry.blk >= ctx.head_block) begin
      bdist = entry.blk - ctx.head_block;
    end else begin
      bdist = ctx.head_block - entry.blk;
    end
    // A full tie goes to this cell, since it arrived later than the upstream ones.
    take = occupied && ahead &&
           (!scan_in.found || (cyl_dist < scan_in.cyl_dist) ||
            ((cyl_dist == scan_in.cyl_dist) && (bdist <= scan_in.bdist)));
  end

  // Pass the best candidate on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    if (take) begin
      scan_out.found    <= 1'b1;
      scan_out.cyl_dist <= cyl_dist;
      scan_out.bdist    <= bdist;
      scan_out.idx      <= cell_index;
    end else begin
      scan_out.found    <= scan_in.found;
      scan_out.cyl_dist <= scan_in.cyl_dist;
      scan_out.bdist    <= scan_in.bdist;
      scan_out.idx      <= scan_in.idx;
    end
  end

endmodule
